/* hdl/epoch_civil_date_converter_macros.svh */
`ifndef EPOCH_CIVIL_DATE_CONVERTER_MACROS_SVH
`define EPOCH_CIVIL_DATE_CONVERTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ECDC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ECDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ecdc_pkg.sv */
package ecdc_pkg;

    localparam int NUM_STAGES = 13;
    localparam int LAST_STAGE = NUM_STAGES - 1;

    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [11:0] YEAR_MIN   = 12'd1970;
    localparam logic [11:0] YEAR_MAX   = 12'd2105;
    localparam logic [11:0] YEAR_NOLEAP = 12'd2100;

    // floor(2^k / d) reciprocals; quotient may come out one low, corrected next stage
    localparam logic [25:0] RECIP_675  = 26'((64'd1 << 35) / 64'd675);
    localparam logic [14:0] RECIP_7    = 15'((64'd1 << 17) / 64'd7);
    localparam logic [5:0]  RECIP_3600 = 6'((64'd1 << 17) / 64'd3600);
    localparam logic [7:0]  RECIP_1460 = 8'((64'd1 << 18) / 64'd1460);
    localparam logic [6:0]  RECIP_60   = 7'((64'd1 << 12) / 64'd60);
    localparam logic [9:0]  RECIP_365  = 10'((64'd1 << 18) / 64'd365);
    localparam logic [3:0]  RECIP_153  = 4'((64'd1 << 11) / 64'd153);

    typedef struct packed {
        logic        req;
        logic        ok;
        logic [6:0]  e_lo;
        logic [24:0] x;
        logic [11:0] cy;
        logic [3:0]  cm;
        logic [4:0]  cd;
        logic [4:0]  ch;
        logic [5:0]  cmi;
        logic [5:0]  cs;
        logic [15:0] days;
        logic [16:0] rem;
        logic        era5;
        logic [17:0] doe;
        logic [13:0] wq;
        logic [2:0]  wd;
        logic [4:0]  hour;
        logic [11:0] r3600;
        logic [6:0]  a1460;
        logic [2:0]  b36524;
        logic        c146096;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [17:0] n;
        logic [8:0]  yoe;
        logic [8:0]  doy;
        logic [3:0]  mp;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [31:0] epoch;
    } pipe_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] r;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
            4'd2:                                        r = 5'd28;
            default:                                     r = 5'd0;
        endcase
        return r;
    endfunction

    // days from March 1 to the first of the month, month counted from March
    function automatic logic [8:0] doy_base(input logic [3:0] mm);
        logic [8:0] r;
        unique case (mm)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] div100(input logic [8:0] y);
        logic [1:0] r;
        if (y >= 9'd300)
        begin
            r = 2'd3;
        end
        else if (y >= 9'd200)
        begin
            r = 2'd2;
        end
        else if (y >= 9'd100)
        begin
            r = 2'd1;
        end
        else
        begin
            r = 2'd0;
        end
        return r;
    endfunction

    function automatic pipe_t stage_fn(input logic [3:0] k, input pipe_t p);
        pipe_t       q;
        logic [50:0] pd;
        logic [25:0] r26;
        logic        leap;
        logic [4:0]  mdays;
        logic        mar;
        logic [3:0]  mm;
        logic [11:0] ya;
        logic [19:0] z;
        logic [16:0] wx;
        logic [31:0] pw;
        logic [22:0] ph;
        logic [16:0] t17;
        logic [25:0] pa;
        logic [17:0] t18;
        logic [18:0] pm;
        logic [11:0] t12;
        logic [27:0] py;
        logic [10:0] mx;
        logic [14:0] pp;
        logic [10:0] t11;
        logic [3:0]  mo;
        q = p;
        case (k)
            4'd1:
            begin
                if (!p.req)
                begin
                    pd = 51'(p.x) * 51'(RECIP_675);
                    q.days = pd[50:35];
                end
                else
                begin
                    leap = (p.cy[1:0] == 2'd0) && (p.cy != YEAR_NOLEAP);
                    mdays = month_len(p.cm) + 5'((p.cm == MONTH_FEB) && leap);
                    q.ok = (p.cy >= YEAR_MIN) && (p.cy <= YEAR_MAX) && (p.cm >= 4'd1)
                        && (p.cm <= 4'd12) && (p.cd >= 5'd1) && (p.cd <= mdays)
                        && (p.ch <= 5'd23) && (p.cmi <= 6'd59) && (p.cs <= 6'd59);
                    mar = p.cm > 4'd2;
                    mm = mar ? p.cm - 4'd3 : p.cm + 4'd9;
                    ya = p.cy - 12'(!mar);
                    q.era5 = ya >= 12'd2000;
                    q.yoe = 9'(ya - (q.era5 ? 12'd2000 : 12'd1600));
                    q.doy = 9'(10'(doy_base(mm)) + 10'(p.cd) - 10'd1);
                    q.rem = 17'(p.ch) * 17'd3600 + 17'(p.cmi) * 17'd60 + 17'(p.cs);
                end
            end
            4'd2:
            begin
                if (!p.req)
                begin
                    r26 = 26'(p.x) - 26'(p.days) * 26'd675;
                    if (r26 >= 26'd675)
                    begin
                        q.days = p.days + 16'd1;
                        r26 = r26 - 26'd675;
                    end
                    q.rem = {r26[9:0], p.e_lo};
                end
                else
                begin
                    q.doe = 18'(p.yoe) * 18'd365 + 18'(p.yoe >> 2)
                        - 18'(div100(p.yoe)) + 18'(p.doy);
                end
            end
            4'd3:
            begin
                if (!p.req)
                begin
                    z = 20'(p.days) + 20'd719468;
                    q.era5 = z >= 20'd730485;
                    q.doe = 18'(z - (q.era5 ? 20'd730485 : 20'd584388));
                    wx = 17'(p.days) + 17'd4;
                    pw = 32'(wx) * 32'(RECIP_7);
                    q.wq = pw[30:17];
                    ph = 23'(p.rem) * 23'(RECIP_3600);
                    q.hour = ph[21:17];
                end
                else
                begin
                    q.days = p.era5 ? 16'(20'(p.doe) + 20'd11017)
                                    : 16'(20'(p.doe) - 20'd135080);
                end
            end
            4'd4:
            begin
                if (!p.req)
                begin
                    wx = 17'(p.days) + 17'd4;
                    t17 = wx - 17'(p.wq) * 17'd7;
                    if (t17 >= 17'd7)
                    begin
                        t17 = t17 - 17'd7;
                    end
                    q.wd = t17[2:0];
                    t17 = p.rem - 17'(p.hour) * 17'd3600;
                    if (t17 >= 17'd3600)
                    begin
                        q.hour = p.hour + 5'd1;
                        t17 = t17 - 17'd3600;
                    end
                    q.r3600 = t17[11:0];
                    pa = 26'(p.doe) * 26'(RECIP_1460);
                    q.a1460 = pa[24:18];
                    if (p.doe >= 18'd146096)
                    begin
                        q.b36524 = 3'd4;
                    end
                    else if (p.doe >= 18'd109572)
                    begin
                        q.b36524 = 3'd3;
                    end
                    else if (p.doe >= 18'd73048)
                    begin
                        q.b36524 = 3'd2;
                    end
                    else if (p.doe >= 18'd36524)
                    begin
                        q.b36524 = 3'd1;
                    end
                    else
                    begin
                        q.b36524 = 3'd0;
                    end
                    q.c146096 = p.doe == 18'd146096;
                end
                else
                begin
                    q.epoch = 32'(33'(p.days) * 33'd86400 + 33'(p.rem));
                end
            end
            4'd5:
            begin
                if (!p.req)
                begin
                    t18 = p.doe - 18'(p.a1460) * 18'd1460;
                    if (t18 >= 18'd1460)
                    begin
                        q.a1460 = p.a1460 + 7'd1;
                    end
                    pm = 19'(p.r3600) * 19'(RECIP_60);
                    q.minute = pm[17:12];
                end
            end
            4'd6:
            begin
                if (!p.req)
                begin
                    q.n = p.doe - 18'(p.a1460) + 18'(p.b36524) - 18'(p.c146096);
                    t12 = p.r3600 - 12'(p.minute) * 12'd60;
                    if (t12 >= 12'd60)
                    begin
                        q.minute = p.minute + 6'd1;
                        t12 = t12 - 12'd60;
                    end
                    q.second = t12[5:0];
                end
            end
            4'd7:
            begin
                if (!p.req)
                begin
                    py = 28'(p.n) * 28'(RECIP_365);
                    q.yoe = py[26:18];
                end
            end
            4'd8:
            begin
                if (!p.req)
                begin
                    t18 = p.n - 18'(p.yoe) * 18'd365;
                    if (t18 >= 18'd365)
                    begin
                        q.yoe = p.yoe + 9'd1;
                    end
                end
            end
            4'd9:
            begin
                if (!p.req)
                begin
                    q.doy = 9'(p.doe - (18'(p.yoe) * 18'd365 + 18'(p.yoe >> 2)
                        - 18'(div100(p.yoe))));
                end
            end
            4'd10:
            begin
                if (!p.req)
                begin
                    mx = 11'(p.doy) * 11'd5 + 11'd2;
                    pp = 15'(mx) * 15'(RECIP_153);
                    q.mp = pp[14:11];
                end
            end
            4'd11:
            begin
                if (!p.req)
                begin
                    mx = 11'(p.doy) * 11'd5 + 11'd2;
                    t11 = mx - 11'(p.mp) * 11'd153;
                    if (t11 >= 11'd153)
                    begin
                        q.mp = p.mp + 4'd1;
                    end
                end
            end
            4'd12:
            begin
                if (!p.req)
                begin
                    mo = (p.mp < 4'd10) ? p.mp + 4'd3 : p.mp - 4'd9;
                    q.month = mo;
                    q.day = 5'(p.doy - doy_base(p.mp) + 9'd1);
                    q.year = 12'(p.yoe) + (p.era5 ? 12'd2000 : 12'd1600)
                        + 12'(mo <= 4'd2);
                    q.wd = (p.wd == 3'd0) ? 3'd7 : p.wd;
                    q.epoch = 32'd0;
                    q.ok = 1'b1;
                end
                else
                begin
                    q.year = 12'd0;
                    q.month = 4'd0;
                    q.day = 5'd0;
                    q.hour = 5'd0;
                    q.minute = 6'd0;
                    q.second = 6'd0;
                    q.wd = 3'd0;
                    q.epoch = p.ok ? p.epoch : 32'd0;
                end
            end
            default:
            begin
                q = p;
            end
        endcase
        return q;
    endfunction

endpackage

/* hdl/ecdc_req_if.sv */
interface ecdc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] epoch_in;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;

    modport source (
        output valid, req_type, epoch_in, year_in, month_in, day_in,
               hour_in, minute_in, second_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, epoch_in, year_in, month_in, day_in,
               hour_in, minute_in, second_in,
        output ready
    );
endinterface

/* hdl/ecdc_res_if.sv */
interface ecdc_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday_out;
    logic        valid_res;

    modport source (
        output valid, epoch_out, year_out, month_out, day_out, hour_out,
               minute_out, second_out, weekday_out, valid_res,
        input  ready
    );
    modport sink (
        input  valid, epoch_out, year_out, month_out, day_out, hour_out,
               minute_out, second_out, weekday_out, valid_res,
        output ready
    );
endinterface

/* hdl/ecdc_pipe_reg.sv */
module ecdc_pipe_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ecdc_pkg::pipe_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ecdc_pkg::pipe_t out_data
);
    import ecdc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    pipe_t data_reg;
    pipe_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                data_next = in_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

/* hdl/epoch_civil_date_converter.sv */
// Converts between 32-bit Unix seconds and a Gregorian date and time. Request type 0
// splits epoch seconds into year, month, day, hour, minute, second and weekday
// (1 = Monday .. 7 = Sunday); type 1 checks a civil date and time (years 1970 to
// 2105) and returns its epoch seconds, or valid_res = 0 and all zero if the
// check fails. One request is taken every cycle unless the output stalls; each result
// passes through the thirteen register stages of the divide-by-constant chain
// (days, era, year of era, month). Results leave in request order, and a
// stalled output holds the whole pipe without losing or repeating anything.
`include "epoch_civil_date_converter_macros.svh"

module epoch_civil_date_converter (
    input logic clk,
    input logic rst_n,
    ecdc_req_if.sink   req,
    ecdc_res_if.source res
);
    import ecdc_pkg::*;

    logic  s_valid    [NUM_STAGES];
    logic  s_in_ready [NUM_STAGES];
    pipe_t s_data     [NUM_STAGES];
    pipe_t s_in_data  [NUM_STAGES];
    pipe_t in_fmt;

    always_comb
    begin
        in_fmt      = '0;
        in_fmt.req  = req.req_type;
        in_fmt.x    = req.epoch_in[31:7];
        in_fmt.e_lo = req.epoch_in[6:0];
        in_fmt.cy   = req.year_in;
        in_fmt.cm   = req.month_in;
        in_fmt.cd   = req.day_in;
        in_fmt.ch   = req.hour_in;
        in_fmt.cmi  = req.minute_in;
        in_fmt.cs   = req.second_in;
    end

    assign req.ready = s_in_ready[0];

    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_stage
        logic in_v;
        logic out_r;

        if (k == 0)
        begin : g_first
            assign in_v         = req.valid;
            assign s_in_data[k] = in_fmt;
        end
        else
        begin : g_rest
            assign in_v         = s_valid[k-1];
            assign s_in_data[k] = stage_fn(4'(k), s_data[k-1]);
        end

        if (k == LAST_STAGE)
        begin : g_out
            assign out_r = res.ready;
        end
        else
        begin : g_mid
            assign out_r = s_in_ready[k+1];
        end

        ecdc_pipe_reg u_reg (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (in_v),
            .in_ready  (s_in_ready[k]),
            .in_data   (s_in_data[k]),
            .out_valid (s_valid[k]),
            .out_ready (out_r),
            .out_data  (s_data[k])
        );
    end

    assign res.valid       = s_valid[LAST_STAGE];
    assign res.epoch_out   = s_data[LAST_STAGE].epoch;
    assign res.year_out    = s_data[LAST_STAGE].year;
    assign res.month_out   = s_data[LAST_STAGE].month;
    assign res.day_out     = s_data[LAST_STAGE].day;
    assign res.hour_out    = s_data[LAST_STAGE].hour;
    assign res.minute_out  = s_data[LAST_STAGE].minute;
    assign res.second_out  = s_data[LAST_STAGE].second;
    assign res.weekday_out = s_data[LAST_STAGE].wd;
    assign res.valid_res   = s_data[LAST_STAGE].ok;

    `ECDC_ASSERT_IMPLY(a_invalid_zero, res.valid && !res.valid_res, res.epoch_out == 32'd0 && res.year_out == 12'd0 && res.weekday_out == 3'd0, "rejected request carries data")
    `ECDC_ASSERT_IMPLY(a_c2e_clears_civil, res.valid && res.epoch_out != 32'd0, res.valid_res && res.year_out == 12'd0 && res.month_out == 4'd0 && res.weekday_out == 3'd0, "epoch result has civil fields")
    `ECDC_ASSERT_IMPLY(a_e2c_ranges, res.valid && res.month_out != 4'd0, res.month_out <= 4'd12 && res.day_out != 5'd0 && res.weekday_out != 3'd0 && res.hour_out <= 5'd23 && res.year_out >= 12'd1970, "civil result out of range")
    `ECDC_ASSERT_NEXT(a_stage_hold, s_valid[1] && !s_in_ready[2], s_valid[1], "stalled stage dropped a request")

endmodule

/* sim/tb_epoch_civil_date_converter.sv */
module tb_epoch_civil_date_converter;
    import ecdc_pkg::*;

    localparam int RAND_ITEMS = 1030;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic REQ_TO_CIVIL = 1'b0;
    localparam logic REQ_TO_EPOCH = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] epoch;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } request_t;

    typedef struct packed {
        logic [31:0] epoch;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic        ok;
    } date_res_t;

    typedef struct {
        request_t  rq;
        bit        typed;
        date_res_t res;
    } row_t;

    logic clk;
    logic rst_n;
    ecdc_req_if req_ch();
    ecdc_res_if res_ch();

    epoch_civil_date_converter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .res   (res_ch.source)
    );

    date_res_t pending_dates[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        calm;
    bit        timed_out = 1'b0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        int unsigned lens[12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12)
            return 0;
        if (m == 2 && is_leap(y))
            return 29;
        return lens[m - 1];
    endfunction

    function automatic date_res_t convert_date(input request_t rq);
        date_res_t      r;
        longint unsigned days, secs, z, era, doe, yoe, doy, mp, mo, ya, mm, y;
        int unsigned    rem, wd;
        r = '0;
        if (rq.req_type == REQ_TO_CIVIL)
        begin
            days = 64'(rq.epoch) / 86400;
            rem = rq.epoch % 86400;
            z = days + 719468;
            era = z / 146097;
            doe = z - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp = (5 * doy + 2) / 153;
            mo = (mp < 10) ? mp + 3 : mp - 9;
            r.day = 5'(doy - (153 * mp + 2) / 5 + 1);
            r.month = 4'(mo);
            r.year = 12'(yoe + era * 400 + ((mo <= 2) ? 1 : 0));
            r.hour = 5'(rem / 3600);
            r.minute = 6'((rem % 3600) / 60);
            r.second = 6'(rem % 60);
            wd = 32'((days + 4) % 7);
            r.weekday = (wd == 0) ? 3'd7 : 3'(wd);
            r.ok = 1'b1;
        end
        else if (rq.year >= 1970 && rq.year <= 2105 && rq.month >= 1 && rq.month <= 12
            && rq.day >= 1 && rq.day <= days_in_month(rq.year, rq.month)
            && rq.hour <= 23 && rq.minute <= 59 && rq.second <= 59)
        begin
            y = 64'(rq.year);
            ya = y - ((rq.month <= 2) ? 1 : 0);
            era = ya / 400;
            yoe = ya - era * 400;
            mm = (rq.month > 2) ? 64'(rq.month) - 3 : 64'(rq.month) + 9;
            doy = (153 * mm + 2) / 5 + rq.day - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * 146097 + doe - 719468;
            secs = days * 86400 + rq.hour * 3600 + rq.minute * 60 + rq.second;
            r.epoch = 32'(secs);
            r.ok = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic request_t civil_req(input int y, input int m, input int d,
                                           input int h, input int mi, input int s);
        request_t rq;
        rq = '0;
        rq.req_type = REQ_TO_EPOCH;
        rq.year = 12'(y);
        rq.month = 4'(m);
        rq.day = 5'(d);
        rq.hour = 5'(h);
        rq.minute = 6'(mi);
        rq.second = 6'(s);
        rq.epoch = $urandom;
        return rq;
    endfunction

    function automatic request_t epoch_req(input logic [31:0] e);
        request_t rq;
        rq = request_t'(71'({$urandom, $urandom, $urandom}));
        rq.req_type = REQ_TO_CIVIL;
        rq.epoch = e;
        return rq;
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int unsigned sel;
        int unsigned y, m;
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            rq = epoch_req($urandom);
        end
        else if (sel < 80)
        begin
            y = $urandom_range(1970, 2105);
            m = $urandom_range(1, 12);
            rq = civil_req(y, m, $urandom_range(1, days_in_month(y, m)),
                $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
        end
        else
        begin
            rq = request_t'(71'({$urandom, $urandom, $urandom}));
            rq.req_type = REQ_TO_EPOCH;
        end
        return rq;
    endfunction

    task automatic send_request(input request_t rq);
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rq.req_type;
        req_ch.epoch_in <= rq.epoch;
        req_ch.year_in <= rq.year;
        req_ch.month_in <= rq.month;
        req_ch.day_in <= rq.day;
        req_ch.hour_in <= rq.hour;
        req_ch.minute_in <= rq.minute;
        req_ch.second_in <= rq.second;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_dates.push_back(convert_date(rq));
        while (!calm && $urandom_range(0, 99) < 36)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= calm || ($urandom_range(0, 99) >= 36);
    end

    always @(posedge clk)
    begin
        date_res_t got, want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = {res_ch.epoch_out, res_ch.year_out, res_ch.month_out, res_ch.day_out,
                res_ch.hour_out, res_ch.minute_out, res_ch.second_out,
                res_ch.weekday_out, res_ch.valid_res};
            if (pending_dates.size() == 0)
            begin
                report_mismatch("unexpected result epoch_out", got.epoch, 0);
            end
            else
            begin
                want = pending_dates.pop_front();
                if (got.epoch !== want.epoch) report_mismatch("epoch_out", got.epoch, want.epoch);
                if (got.year !== want.year) report_mismatch("year_out", got.year, want.year);
                if (got.month !== want.month) report_mismatch("month_out", got.month, want.month);
                if (got.day !== want.day) report_mismatch("day_out", got.day, want.day);
                if (got.hour !== want.hour) report_mismatch("hour_out", got.hour, want.hour);
                if (got.minute !== want.minute)
                    report_mismatch("minute_out", got.minute, want.minute);
                if (got.second !== want.second)
                    report_mismatch("second_out", got.second, want.second);
                if (got.weekday !== want.weekday)
                    report_mismatch("weekday_out", got.weekday, want.weekday);
                if (got.ok !== want.ok) report_mismatch("valid_res", got.ok, want.ok);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        row_t     rows[$];
        row_t     r;
        date_res_t d;
        int       drain;
        rst_n = 1'b0;
        calm = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = 1'b0;
        req_ch.epoch_in = '0;
        req_ch.year_in = '0;
        req_ch.month_in = '0;
        req_ch.day_in = '0;
        req_ch.hour_in = '0;
        req_ch.minute_in = '0;
        req_ch.second_in = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // epoch zero: 1970-01-01, Thursday
        d = '0; d.year = 1970; d.month = 1; d.day = 1; d.weekday = 4; d.ok = 1;
        r.rq = epoch_req(32'd0); r.typed = 1; r.res = d; rows.push_back(r);
        // top of range: 2106-02-07 06:28:15, Sunday
        d = '0; d.year = 2106; d.month = 2; d.day = 7; d.hour = 6; d.minute = 28;
        d.second = 15; d.weekday = 7; d.ok = 1;
        r.rq = epoch_req(32'hFFFF_FFFF); r.typed = 1; r.res = d; rows.push_back(r);
        d = '0; d.ok = 1;
        r.rq = civil_req(1970, 1, 1, 0, 0, 0); r.typed = 1; r.res = d; rows.push_back(r);
        d = '0;
        r.res = d; r.typed = 1;
        r.rq = civil_req(1969, 12, 31, 23, 59, 59); rows.push_back(r);
        r.rq = civil_req(2106, 1, 1, 0, 0, 0); rows.push_back(r);
        r.rq = civil_req(2000, 0, 1, 0, 0, 0); rows.push_back(r);
        r.rq = civil_req(2000, 13, 1, 0, 0, 0); rows.push_back(r);
        r.rq = civil_req(2000, 15, 31, 31, 63, 63); rows.push_back(r);
        r.rq = civil_req(2000, 5, 0, 0, 0, 0); rows.push_back(r);
        r.rq = civil_req(2001, 2, 29, 0, 0, 0); rows.push_back(r);
        r.rq = civil_req(2100, 2, 29, 0, 0, 0); rows.push_back(r);
        r.rq = civil_req(2000, 4, 31, 0, 0, 0); rows.push_back(r);
        r.rq = civil_req(2000, 1, 1, 24, 0, 0); rows.push_back(r);
        r.rq = civil_req(2000, 1, 1, 0, 60, 0); rows.push_back(r);
        r.rq = civil_req(2000, 1, 1, 0, 0, 60); rows.push_back(r);
        r.rq = civil_req(4095, 1, 1, 0, 0, 0); rows.push_back(r);
        r.rq = civil_req(0, 1, 1, 0, 0, 0); rows.push_back(r);
        r.typed = 0;
        r.rq = civil_req(2000, 2, 29, 12, 30, 30); rows.push_back(r);
        r.rq = civil_req(2105, 12, 31, 23, 59, 59); rows.push_back(r);
        r.rq = civil_req(2106 - 1, 1, 31, 0, 0, 0); rows.push_back(r);
        r.rq = epoch_req(32'd951782400); rows.push_back(r);
        r.rq = epoch_req(32'd4107542399); rows.push_back(r);
        r.rq = epoch_req(32'h8000_0000); rows.push_back(r);
        r.rq = epoch_req(32'h7FFF_FFFF); rows.push_back(r);

        foreach (rows[i])
        begin
            send_request(rows[i].rq);
            if (rows[i].typed && pending_dates[$] !== rows[i].res)
                report_mismatch("directed row expectation", i, 0);
        end

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            calm = (n >= 400 && n < 550);
            send_request(random_request());
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        while (pending_dates.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < DRAIN_CYCLES)
        begin
            @(posedge clk);
            drain++;
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* files.f */
+incdir+hdl
hdl/ecdc_pkg.sv
hdl/ecdc_req_if.sv
hdl/ecdc_res_if.sv
hdl/ecdc_pipe_reg.sv
hdl/epoch_civil_date_converter.sv
sim/tb_epoch_civil_date_converter.sv
